// File: hdl/dlu_pkg.sv
// ----------------------------------------------------------------------------
// dlu_pkg: shared types for the depth label unprojection block
// Request structs for both channels, configuration bundle, register indexes.
// ----------------------------------------------------------------------------
package dlu_pkg;

    typedef struct packed {
        logic [11:0] pix_row;
        logic [11:0] pix_col;
        logic [5:0]  depth_label;
        logic        label_unknown;
        logic [7:0]  in_blue;
        logic [7:0]  in_green;
        logic [7:0]  in_red;
    } pix_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [31:0]        point_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
    } point_t;

    typedef struct packed {
        logic [31:0] near_depth;
        logic [31:0] far_depth;
        logic [2:0]  scale_shift;
        logic [31:0] ik_xx;
        logic [31:0] ik_xy;
        logic [31:0] ik_xo;
        logic [31:0] ik_yy;
        logic [31:0] ik_yo;
    } cfg_t;

    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_NEAR_DEPTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FAR_DEPTH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_SHIFT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IK_XX       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IK_XY       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_IK_XO       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_IK_YY       = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_IK_YO       = 3'd7;

    localparam logic [31:0] NEAR_DEPTH_RST = 32'd65536;
    localparam logic [31:0] FAR_DEPTH_RST  = 32'd6553600;
    localparam logic [31:0] IK_ONE_RST     = 32'd268435456;

endpackage

// File: hdl/dlu_front.sv
// ----------------------------------------------------------------------------
// dlu_front: request intake and setup products
// Drops unknown pixels, forms divider operands and ray direction, feeds queue.
// ----------------------------------------------------------------------------
module dlu_front #(
    parameter int NUM_LABELS = 64,
    parameter int COORD_BITS = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  dlu_pkg::cfg_t  cfg,
    input  logic           pix_valid,
    output logic           pix_stall,
    input  dlu_pkg::pix_t  pix,
    input  logic           q_full,
    output logic           q_push,
    output logic [(64 + $clog2(NUM_LABELS)) + (33 + $clog2(NUM_LABELS))
                  + 2 * (COORD_BITS + 42) + 23 : 0] q_data
);
    import dlu_pkg::*;

    localparam int KW    = $clog2(NUM_LABELS);
    localparam int K     = NUM_LABELS - 1;
    localparam int UW    = COORD_BITS + 7;
    localparam int PW    = COORD_BITS + 40;
    localparam int DIR_W = COORD_BITS + 42;
    localparam int NUM_W = 64 + KW;
    localparam int DEN_W = 33 + KW;

    logic              front_en;
    logic [KW-1:0]     lab_c;
    logic [UW-1:0]     u_c;
    logic [UW-1:0]     v_c;

    logic                 f1_v_reg;
    logic [63:0]          fn_reg;
    logic [32+KW-1:0]     fa_reg;
    logic [32+KW-1:0]     nb_reg;
    logic signed [PW-1:0] pxx_reg;
    logic signed [PW-1:0] pxy_reg;
    logic signed [PW-1:0] pyy_reg;
    logic [23:0]          rgb_reg;

    logic [NUM_W-1:0]        num_c;
    logic [DEN_W-1:0]        den_c;
    logic signed [DIR_W-1:0] dx_c;
    logic signed [DIR_W-1:0] dy_c;

    assign front_en  = !f1_v_reg || !q_full;
    assign pix_stall = !front_en;

    // clamp label to the last plane
    assign lab_c = ({26'd0, pix.depth_label} > 32'(K)) ? KW'(K) : KW'(pix.depth_label);

    assign u_c = (UW'(pix.pix_col) & UW'({COORD_BITS{1'b1}})) << cfg.scale_shift;
    assign v_c = (UW'(pix.pix_row) & UW'({COORD_BITS{1'b1}})) << cfg.scale_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
        end
        else if (front_en)
        begin
            f1_v_reg <= pix_valid && !pix.label_unknown;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            fn_reg  <= 64'(cfg.far_depth) * 64'(cfg.near_depth);
            fa_reg  <= (32+KW)'(cfg.far_depth) * (32+KW)'(KW'(K) - lab_c);
            nb_reg  <= (32+KW)'(cfg.near_depth) * (32+KW)'(lab_c);
            pxx_reg <= $signed(cfg.ik_xx) * $signed({1'b0, u_c});
            pxy_reg <= $signed(cfg.ik_xy) * $signed({1'b0, v_c});
            pyy_reg <= $signed(cfg.ik_yy) * $signed({1'b0, v_c});
            rgb_reg <= {pix.in_red, pix.in_green, pix.in_blue};
        end
    end

    assign num_c = NUM_W'(fn_reg) * NUM_W'(K);
    assign den_c = DEN_W'(fa_reg) + DEN_W'(nb_reg);
    assign dx_c  = DIR_W'(pxx_reg) + DIR_W'(pxy_reg) + DIR_W'($signed(cfg.ik_xo));
    assign dy_c  = DIR_W'(pyy_reg) + DIR_W'($signed(cfg.ik_yo));

    assign q_push = f1_v_reg && !q_full;
    assign q_data = {num_c, den_c, dx_c, dy_c, rgb_reg};

endmodule

// File: hdl/dlu_queue.sv
// ----------------------------------------------------------------------------
// dlu_queue: small request queue between front and back
// Register-based FIFO; decouples front stall from back stall.
// ----------------------------------------------------------------------------
module dlu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    import dlu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");
    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance");
`endif

endmodule

// File: hdl/dlu_back.sv
// ----------------------------------------------------------------------------
// dlu_back: depth division and ray scaling
// 32-stage restoring divider, one quotient bit per stage, then Q16.16 scaling.
// ----------------------------------------------------------------------------
module dlu_back #(
    parameter int NUM_LABELS = 64,
    parameter int COORD_BITS = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    output logic            q_pop,
    input  logic [(64 + $clog2(NUM_LABELS)) + (33 + $clog2(NUM_LABELS))
                  + 2 * (COORD_BITS + 42) + 23 : 0] q_data,
    output logic            point_valid,
    input  logic            point_stall,
    output dlu_pkg::point_t point
);
    import dlu_pkg::*;

    localparam int KW    = $clog2(NUM_LABELS);
    localparam int DIR_W = COORD_BITS + 42;
    localparam int HI_W  = DIR_W - 32;
    localparam int NUM_W = 64 + KW;
    localparam int DEN_W = 33 + KW;
    localparam int SDW   = 2 * (DIR_W + 1) + 26;
    localparam int SW    = DIR_W + 32;
    localparam int NST   = 32;

    logic back_en;

    logic [NUM_W-1:0]        num_i;
    logic [DEN_W-1:0]        den_i;
    logic signed [DIR_W-1:0] dx_i;
    logic signed [DIR_W-1:0] dy_i;
    logic [23:0]             rgb_i;
    logic [DIR_W-1:0]        magx_i;
    logic [DIR_W-1:0]        magy_i;
    logic [NUM_W-33:0]       nhi_i;

    // divider stages: 0 is the overflow check, 1..32 each settle one bit
    logic             v_reg   [NST+1];
    logic [DEN_W-1:0] rem_reg [NST+1];
    logic [DEN_W-1:0] den_reg [NST+1];
    logic [31:0]      low_reg [NST+1];
    logic [31:0]      quo_reg [NST+1];
    logic [SDW-1:0]   sd_reg  [NST+1];

    logic [DEN_W:0]   trial   [NST+1];
    logic             ge      [NST+1];

    logic [DIR_W-1:0] magx_s;
    logic [DIR_W-1:0] magy_s;
    logic             negx_s;
    logic             negy_s;
    logic [23:0]      rgb_s;
    logic             zero_s;
    logic             over_s;
    logic [31:0]      depth_s;

    logic             p_v_reg;
    logic [63:0]      p0x_reg;
    logic [HI_W+31:0] p1x_reg;
    logic [63:0]      p0y_reg;
    logic [HI_W+31:0] p1y_reg;
    logic             pnx_reg;
    logic             pny_reg;
    logic [31:0]      pz_reg;
    logic [23:0]      prgb_reg;

    logic             r_v_reg;
    logic [SW-1:0]    sx_reg;
    logic [SW-1:0]    sy_reg;
    logic             rnx_reg;
    logic             rny_reg;
    logic [31:0]      rz_reg;
    logic [23:0]      rrgb_reg;

    logic             out_v_reg;
    point_t           out_reg;
    logic [31:0]      x_next;
    logic [31:0]      y_next;

    function automatic logic [31:0] sat_round(input logic [SW-1:0] s, input logic neg);
        logic [SW-29:0] r;
        logic           big;
        r   = s[SW-1:28];
        big = |r[SW-29:31];
        if (big)
        begin
            sat_round = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            sat_round = neg ? (32'd0 - r[31:0]) : r[31:0];
        end
    endfunction

    assign back_en = !out_v_reg || !point_stall;
    assign q_pop   = back_en && !q_empty;

    assign {num_i, den_i, dx_i, dy_i, rgb_i} = q_data;
    assign magx_i = dx_i[DIR_W-1] ? DIR_W'(-dx_i) : DIR_W'(dx_i);
    assign magy_i = dy_i[DIR_W-1] ? DIR_W'(-dy_i) : DIR_W'(dy_i);
    assign nhi_i  = num_i[NUM_W-1:32];

    always_comb
    begin
        for (int i = 1; i <= NST; i++)
        begin
            trial[i] = {rem_reg[i-1], low_reg[i-1][31]};
            ge[i]    = trial[i] >= {1'b0, den_reg[i-1]};
        end
        trial[0] = '0;
        ge[0]    = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NST; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            p_v_reg   <= 1'b0;
            r_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (back_en)
        begin
            v_reg[0] <= !q_empty;
            for (int i = 1; i <= NST; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            p_v_reg   <= v_reg[NST];
            r_v_reg   <= p_v_reg;
            out_v_reg <= r_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            rem_reg[0] <= DEN_W'(nhi_i);
            den_reg[0] <= den_i;
            low_reg[0] <= num_i[31:0];
            quo_reg[0] <= '0;
            sd_reg[0]  <= {dx_i[DIR_W-1], magx_i, dy_i[DIR_W-1], magy_i, rgb_i,
                           (den_i == '0), (DEN_W'(nhi_i) >= den_i)};
            for (int i = 1; i <= NST; i++)
            begin
                rem_reg[i] <= ge[i] ? DEN_W'(trial[i] - {1'b0, den_reg[i-1]})
                                    : DEN_W'(trial[i]);
                den_reg[i] <= den_reg[i-1];
                low_reg[i] <= {low_reg[i-1][30:0], 1'b0};
                quo_reg[i] <= {quo_reg[i-1][30:0], ge[i]};
                sd_reg[i]  <= sd_reg[i-1];
            end
        end
    end

    assign {negx_s, magx_s, negy_s, magy_s, rgb_s, zero_s, over_s} = sd_reg[NST];
    assign depth_s = zero_s ? 32'd0 : (over_s ? 32'hFFFF_FFFF : quo_reg[NST]);

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            p0x_reg  <= 64'(magx_s[31:0]) * 64'(depth_s);
            p1x_reg  <= (HI_W+32)'(magx_s[DIR_W-1:32]) * (HI_W+32)'(depth_s);
            p0y_reg  <= 64'(magy_s[31:0]) * 64'(depth_s);
            p1y_reg  <= (HI_W+32)'(magy_s[DIR_W-1:32]) * (HI_W+32)'(depth_s);
            pnx_reg  <= negx_s;
            pny_reg  <= negy_s;
            pz_reg   <= depth_s;
            prgb_reg <= rgb_s;

            // add half an LSB of Q16.16 for round-half-away on the magnitude
            sx_reg   <= SW'(p0x_reg) + (SW'(p1x_reg) << 32) + SW'(1 << 27);
            sy_reg   <= SW'(p0y_reg) + (SW'(p1y_reg) << 32) + SW'(1 << 27);
            rnx_reg  <= pnx_reg;
            rny_reg  <= pny_reg;
            rz_reg   <= pz_reg;
            rrgb_reg <= prgb_reg;

            out_reg.point_x   <= x_next;
            out_reg.point_y   <= y_next;
            out_reg.point_z   <= rz_reg;
            out_reg.out_red   <= rrgb_reg[23:16];
            out_reg.out_green <= rrgb_reg[15:8];
            out_reg.out_blue  <= rrgb_reg[7:0];
        end
    end

    assign x_next = sat_round(sx_reg, rnx_reg);
    assign y_next = sat_round(sy_reg, rny_reg);

    assign point_valid = out_v_reg;
    assign point       = out_reg;

endmodule

// File: hdl/depth_label_unproject_to_point.sv
// ----------------------------------------------------------------------------
// depth_label_unproject_to_point: labelled pixel to colored 3D point
// Config registers, front intake, request queue and divider/scaling back end.
// ----------------------------------------------------------------------------
// Takes one pixel request per cycle while not stalled and, unless it is
// flagged unknown, returns one point: depth z = far*near*(N-1) /
// (far*(N-1-L) + near*L) in Q16.16, truncated and saturated to 32 bits (0 if
// the divisor is zero), and x, y = inverse-intrinsic ray times depth, rounded
// half away from zero and saturated. Sustained rate is one pixel per clock
// while neither side stalls. The path is 1 front setup stage, the queue, then
// 36 back stages dominated by a 32-stage restoring divider that settles one
// quotient bit per stage, plus two product/round stages and the output
// register. A 4-entry queue sits between intake and back end, so a stall on
// the output side reaches the input only after the queue fills. Registers may
// only be written while no request is in flight.
module depth_label_unproject_to_point #(
    parameter int NUM_LABELS = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [dlu_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [31:0]                     wr_data,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  dlu_pkg::pix_t                   pix,
    output logic                            point_valid,
    input  logic                            point_stall,
    output dlu_pkg::point_t                 point
);
    import dlu_pkg::*;

    localparam int KW    = $clog2(NUM_LABELS);
    localparam int QW    = (64 + KW) + (33 + KW) + 2 * (COORD_BITS + 42) + 24;
    localparam int QDEPTH = 4;

    cfg_t            cfg_reg;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    logic [QW-1:0]   q_wdata;
    logic [QW-1:0]   q_rdata;

    // register file, write only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_depth  <= NEAR_DEPTH_RST;
            cfg_reg.far_depth   <= FAR_DEPTH_RST;
            cfg_reg.scale_shift <= '0;
            cfg_reg.ik_xx       <= IK_ONE_RST;
            cfg_reg.ik_xy       <= '0;
            cfg_reg.ik_xo       <= '0;
            cfg_reg.ik_yy       <= IK_ONE_RST;
            cfg_reg.ik_yo       <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_NEAR_DEPTH:  cfg_reg.near_depth  <= wr_data;
                REG_FAR_DEPTH:   cfg_reg.far_depth   <= wr_data;
                REG_SCALE_SHIFT: cfg_reg.scale_shift <= wr_data[2:0];
                REG_IK_XX:       cfg_reg.ik_xx       <= wr_data;
                REG_IK_XY:       cfg_reg.ik_xy       <= wr_data;
                REG_IK_XO:       cfg_reg.ik_xo       <= wr_data;
                REG_IK_YY:       cfg_reg.ik_yy       <= wr_data;
                REG_IK_YO:       cfg_reg.ik_yo       <= wr_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // intake: drops unknown pixels, builds divider operands and ray
    dlu_front #(
        .NUM_LABELS (NUM_LABELS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    dlu_queue #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // back end: divider pipeline, ray scaling, output register
    dlu_back #(
        .NUM_LABELS (NUM_LABELS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_data      (q_rdata),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

endmodule

// File: tb/tb_depth_label_unproject_to_point.sv
// ----------------------------------------------------------------------------
// tb_depth_label_unproject_to_point: self-checking bench for the unprojection block
// Drives pixel requests with random gaps and output stalls, predicts each point
// from a local model of depth, ray and color, and checks results in order.
// ----------------------------------------------------------------------------

// Scoreboard: holds predicted points in arrival order.
class point_board;
    dlu_pkg::point_t pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // Note an accepted pixel request and the point it is expected to produce.
    function void note_pixel(bit makes_point, dlu_pkg::point_t pt);
        if (makes_point)
            pending = {pending, pt};
    endfunction

    task report(string what);
        $display("MISMATCH: %s", what);
        errors++;
    endtask

    // Compare one accepted output point with the oldest prediction.
    task check_point(dlu_pkg::point_t got);
        dlu_pkg::point_t exp_pt;
        if (pending.size() == 0)
        begin
            report($sformatf("unexpected point %h", got));
            return;
        end
        exp_pt = pending.pop_front();
        if (got.point_x !== exp_pt.point_x)
            report($sformatf("point_x got %h exp %h", got.point_x, exp_pt.point_x));
        if (got.point_y !== exp_pt.point_y)
            report($sformatf("point_y got %h exp %h", got.point_y, exp_pt.point_y));
        if (got.point_z !== exp_pt.point_z)
            report($sformatf("point_z got %h exp %h", got.point_z, exp_pt.point_z));
        if (got.out_red !== exp_pt.out_red)
            report($sformatf("out_red got %h exp %h", got.out_red, exp_pt.out_red));
        if (got.out_green !== exp_pt.out_green)
            report($sformatf("out_green got %h exp %h", got.out_green, exp_pt.out_green));
        if (got.out_blue !== exp_pt.out_blue)
            report($sformatf("out_blue got %h exp %h", got.out_blue, exp_pt.out_blue));
    endtask
endclass

module tb_depth_label_unproject_to_point;
    import dlu_pkg::*;

    localparam int NUM_LABELS = 64;
    localparam int LAST_LABEL = NUM_LABELS - 1;
    localparam int CYCLE_LIMIT = 400000;
    // Settling margin for the pipeline stages plus a 4-entry queue.
    localparam int DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [31:0] wr_data;
    logic        pix_valid;
    logic        pix_stall;
    pix_t        pix;
    logic        point_valid;
    logic        point_stall;
    point_t      point;

    // Local copy of the configuration registers.
    logic [31:0] near_q, far_q, ik_xx_q, ik_xy_q, ik_xo_q, ik_yy_q, ik_yo_q;
    logic [2:0]  shift_q;

    point_board board;
    int cycle_count;
    // Stall control: idle_pct is the chance of a gap; hold_cycles forces a long hold.
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    depth_label_unproject_to_point dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix         (pix),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Depth from label: far*near*(N-1) / (far*(N-1-L) + near*L), truncated,
    // zero on a zero divisor, all ones above 32 bits.
    function automatic logic [31:0] label_depth(logic [5:0] lab_in);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        int unsigned  lab;
        lab = (lab_in > LAST_LABEL) ? LAST_LABEL : lab_in;
        den = 128'(far_q) * (LAST_LABEL - lab) + 128'(near_q) * lab;
        num = 128'(far_q) * 128'(near_q) * LAST_LABEL;
        if (den == 0)
            return 32'd0;
        quo = num / den;
        if (quo > 128'hFFFF_FFFF)
            return 32'hFFFF_FFFF;
        return quo[31:0];
    endfunction

    // Ray component (Q36.28) times depth (Q16.16) to Q16.16, round half away, saturate.
    function automatic logic [31:0] ray_times_depth(logic signed [63:0] dir,
                                                    logic [31:0] depth);
        logic          neg;
        logic [63:0]   mag;
        logic [127:0]  prod;
        logic [127:0]  q;
        neg = dir < 0;
        mag = neg ? -dir : dir;
        prod = 128'(mag) * 128'(depth) + (128'd1 << 27);
        q = prod >> 28;
        if (neg)
        begin
            if (q >= 128'h8000_0000)
                return 32'h8000_0000;
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic point_t predict_point(pix_t p);
        point_t             pt;
        logic [31:0]        depth;
        logic signed [63:0] u, v, dx, dy;
        depth = label_depth(p.depth_label);
        u = 64'(p.pix_col) << shift_q;
        v = 64'(p.pix_row) << shift_q;
        dx = 64'(signed'(ik_xx_q)) * u + 64'(signed'(ik_xy_q)) * v + 64'(signed'(ik_xo_q));
        dy = 64'(signed'(ik_yy_q)) * v + 64'(signed'(ik_yo_q));
        pt.point_x   = ray_times_depth(dx, depth);
        pt.point_y   = ray_times_depth(dy, depth);
        pt.point_z   = depth;
        pt.out_red   = p.in_red;
        pt.out_green = p.in_green;
        pt.out_blue  = p.in_blue;
        return pt;
    endfunction

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_NEAR_DEPTH:  near_q  = val;
            REG_FAR_DEPTH:   far_q   = val;
            REG_SCALE_SHIFT: shift_q = val[2:0];
            REG_IK_XX:       ik_xx_q = val;
            REG_IK_XY:       ik_xy_q = val;
            REG_IK_XO:       ik_xo_q = val;
            REG_IK_YY:       ik_yy_q = val;
            default:         ik_yo_q = val;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] nd, logic [31:0] fd, logic [2:0] sh,
                             logic [31:0] xx, logic [31:0] xy, logic [31:0] xo,
                             logic [31:0] yy, logic [31:0] yo);
        write_reg(REG_NEAR_DEPTH, nd);
        write_reg(REG_FAR_DEPTH, fd);
        write_reg(REG_SCALE_SHIFT, 32'(sh));
        write_reg(REG_IK_XX, xx);
        write_reg(REG_IK_XY, xy);
        write_reg(REG_IK_XO, xo);
        write_reg(REG_IK_YY, yy);
        write_reg(REG_IK_YO, yo);
    endtask

    // Offer one pixel request; hold it until accepted. Entered at a clock edge.
    // Valid stays high across back-to-back requests, it is only lowered on an
    // idle gap.
    task automatic send_pixel(pix_t p);
        while (($urandom_range(99) < send_idle_pct))
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        // Wait for the edge where it is taken.
        do
            @(posedge clk);
        while (pix_stall);
        board.note_pixel(!p.label_unknown, predict_point(p));
    endtask

    // Wait until every prediction has been matched, then let the pipe settle.
    task automatic drain();
        pix_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic pix_t random_pixel(int unknown_pct);
        pix_t p;
        p = pix_t'($bits(pix_t)'({$urandom, $urandom}));
        p.label_unknown = ($urandom_range(99) < unknown_pct);
        // Mostly full-range coordinates, sometimes small.
        if ($urandom_range(3) == 0)
        begin
            p.pix_row = 12'($urandom_range(63));
            p.pix_col = 12'($urandom_range(63));
        end
        return p;
    endfunction

    task automatic send_random(int count);
        repeat (count) send_pixel(random_pixel(15));
    endtask

    // Receiver: random stall, plus a forced long hold when hold_cycles is set.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            point_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            point_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && point_valid && !point_stall)
            board.check_point(point);
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** depth_label_unproject_to_point: FAILED **");
            $finish;
        end
    end

    initial
    begin
        pix_t p;
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        pix_valid = 1'b0;
        pix = '0;
        point_stall = 1'b0;
        cycle_count = 0;
        send_idle_pct = 10;
        recv_idle_pct = 10;
        hold_cycles = 0;
        near_q = NEAR_DEPTH_RST;
        far_q = FAR_DEPTH_RST;
        shift_q = '0;
        ik_xx_q = IK_ONE_RST;
        ik_xy_q = '0;
        ik_xo_q = '0;
        ik_yy_q = IK_ONE_RST;
        ik_yo_q = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers, label and coordinate extremes, unknown pixel.
        p = '0;
        send_pixel(p);
        p.depth_label = 6'd63; p.pix_row = 12'hFFF; p.pix_col = 12'hFFF;
        p.in_red = 8'hFF; p.in_green = 8'h00; p.in_blue = 8'hA5;
        send_pixel(p);
        p.depth_label = 6'd31;
        send_pixel(p);
        p.label_unknown = 1'b1;
        send_pixel(p);
        drain();

        // Directed: saturating ray with extreme coefficients and max shift.
        write_all(32'h0000_0001, 32'hFFFF_FFFF, 3'd7, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        p = '0; p.pix_row = 12'hFFF; p.pix_col = 12'h001;
        send_pixel(p);
        p.depth_label = 6'd63;
        send_pixel(p);
        p.pix_col = 12'hFFF; p.pix_row = 12'h000;
        send_pixel(p);
        drain();

        // Directed: far below near, then zero depth registers.
        write_all(32'd6553600, 32'd65536, 3'd1, 32'h0100_0000, 32'hFFF0_0000,
                  32'h1000_0000, 32'hF000_0000, 32'h0800_0000);
        p = '0; p.pix_row = 12'd100; p.pix_col = 12'd200;
        send_pixel(p);
        p.depth_label = 6'd20;
        send_pixel(p);
        drain();
        write_reg(REG_NEAR_DEPTH, 32'd0);
        write_reg(REG_FAR_DEPTH, 32'd0);
        p.depth_label = 6'd0;
        send_pixel(p);
        p.depth_label = 6'd63;
        send_pixel(p);
        drain();
        write_reg(REG_FAR_DEPTH, 32'd65536);
        p.depth_label = 6'd0;
        send_pixel(p);
        p.depth_label = 6'd63;
        send_pixel(p);
        drain();

        // Random phase with the reset settings.
        write_all(NEAR_DEPTH_RST, FAR_DEPTH_RST, 3'd0, IK_ONE_RST, 32'd0,
                  32'd0, IK_ONE_RST, 32'd0);
        send_random(300);
        drain();

        // Stretch with no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(32'd32768, 32'd2000000, 3'd2, 32'h0033_0000, 32'h0000_1000,
                  32'hF800_0000, 32'h0033_0000, 32'hFA00_0000);
        send_random(300);
        drain();
        send_idle_pct = 10;
        recv_idle_pct = 10;

        // Long receiver hold while the sender keeps offering: fills the queue.
        @(posedge clk);
        hold_cycles <= 200;
        send_random(300);
        drain();

        repeat (4)
        begin
            write_all($urandom_range(1, 32'hFFFF_FFFF), $urandom, 3'($urandom_range(7)),
                      $urandom, $urandom, $urandom, $urandom, $urandom);
            send_random(250);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("** depth_label_unproject_to_point: PASSED **");
        else
            $display("** depth_label_unproject_to_point: FAILED **");
        $finish;
    end
endmodule
